// ===== rtl/era_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and types of the event rate averager
package era_pkg;

   // default build configuration
   localparam int NUM_COUNTERS_DEF = 4;
   localparam int PERIOD_SLOTS_DEF = 3;
   localparam int COUNT_BITS_DEF   = 32;

   // fixed field widths
   localparam int CMD_W     = 1;
   localparam int IDX_W     = 2;
   localparam int TOCK_W    = 32;
   localparam int AVG_W     = 36;
   localparam int EVT_W     = 32;
   localparam int PERIOD_W  = 16;
   localparam int MASK_W    = 4;
   localparam int NUM_SLOTS = 4;

   // results per tock
   localparam int MAX_RESULTS = 12;
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

   // register port
   localparam int PADDR_W = 5;
   localparam int PDATA_W = 32;
   localparam int REGSEL_W = 3;

   localparam logic [REGSEL_W-1:0] REG_ENABLE_MASK = 3'd0;
   localparam logic [REGSEL_W-1:0] REG_PERIOD_0    = 3'd1;
   localparam logic [REGSEL_W-1:0] REG_PERIOD_1    = 3'd2;
   localparam logic [REGSEL_W-1:0] REG_PERIOD_2    = 3'd3;
   localparam logic [REGSEL_W-1:0] REG_PERIOD_3    = 3'd4;

   // item commands
   localparam logic [CMD_W-1:0] CMD_COUNT = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TOCK  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PHASE,
      ST_LOAD,
      ST_COMMIT
   } state_type;

   typedef logic [NUM_SLOTS-1:0][PERIOD_W-1:0] period_bank_type;

   typedef struct packed {
      logic             count_inc;
      logic             phase_start;
      logic             pair_load;
      logic             pair_commit;
      logic             first_pair;
      logic             emit;
      logic             last;
      logic [IDX_W-1:0] cur_c;
      logic [IDX_W-1:0] cur_p;
   } ctrl_cmd_type;

   typedef struct packed {
      logic phase_done;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/era_req_if.sv =====
`timescale 1ns / 1ps
// input item channel of the event rate averager
interface era_req_if import era_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [IDX_W-1:0]  counter_index;
   logic [TOCK_W-1:0] tock_number;

   modport source (output valid, cmd, counter_index, tock_number, input ready);
   modport sink (input valid, cmd, counter_index, tock_number, output ready);
endinterface

// ===== rtl/era_rsp_if.sv =====
`timescale 1ns / 1ps
// result channel of the event rate averager
interface era_rsp_if import era_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] which_counter;
   logic [IDX_W-1:0] which_period;
   logic [AVG_W-1:0] average_value;
   logic [EVT_W-1:0] events_since_tock;
   logic             was_updated;
   logic             last_result;

   modport source (output valid, which_counter, which_period, average_value,
                   events_since_tock, was_updated, last_result, input ready);
   modport sink (input valid, which_counter, which_period, average_value,
                 events_since_tock, was_updated, last_result, output ready);
endinterface

// ===== rtl/era_phase.sv =====
`timescale 1ns / 1ps
// bit-serial tock number remainder, one lane per averaging period
module era_phase import era_pkg::*; #(
   parameter int PERIOD_SLOTS = PERIOD_SLOTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [TOCK_W-1:0]       tock_number,
   input  period_bank_type         periods,
   output logic                    done,
   output logic [PERIOD_SLOTS-1:0] hit
);

   localparam int BITS_W = $clog2(TOCK_W + 1);

   logic [BITS_W-1:0]               bits_left_ff, bits_left_in;
   logic [TOCK_W-1:0]               tock_ff, tock_in;
   logic [PERIOD_SLOTS-1:0][PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_SLOTS-1:0][PERIOD_W-1:0] per_eff;

   always_comb begin
      for (int i = 0; i < PERIOD_SLOTS; i++) begin
         per_eff[i] = (periods[i] == '0) ? PERIOD_W'(1) : periods[i];
         hit[i]     = (rem_ff[i] == per_eff[i] - PERIOD_W'(1));
      end
   end

   assign done = (bits_left_ff == '0);

   always_comb begin
      logic [PERIOD_W:0] shifted;
      bits_left_in = bits_left_ff;
      tock_in      = tock_ff;
      rem_in       = rem_ff;
      shifted      = '0;
      if (start) begin
         bits_left_in = BITS_W'(TOCK_W);
         tock_in      = tock_number;
         rem_in       = '0;
      end else if (!done) begin
         bits_left_in = bits_left_ff - BITS_W'(1);
         tock_in      = {tock_ff[TOCK_W-2:0], 1'b0};
         for (int i = 0; i < PERIOD_SLOTS; i++) begin
            shifted = {rem_ff[i], tock_ff[TOCK_W-1]};
            if (shifted >= {1'b0, per_eff[i]}) begin
               shifted = shifted - {1'b0, per_eff[i]};
            end
            rem_in[i] = shifted[PERIOD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_left_ff <= '0;
      end else begin
         bits_left_ff <= bits_left_in;
      end
   end

   always_ff @(posedge clock) begin
      tock_ff <= tock_in;
      rem_ff  <= rem_in;
   end

endmodule

// ===== rtl/era_csr.sv =====
`timescale 1ns / 1ps
// register bank: enable mask and the four period registers
module era_csr import era_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output logic [MASK_W-1:0]  enable_mask,
   output period_bank_type    periods
);

   logic [MASK_W-1:0] enable_ff, enable_in;
   period_bank_type   period_ff, period_in;
   logic [REGSEL_W-1:0] regsel;
   logic                wr_strobe;

   // word addressed, byte lane bits ignored
   assign regsel    = paddr[PADDR_W-1:2];
   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite && pready;

   always_comb begin
      enable_in = enable_ff;
      period_in = period_ff;
      if (wr_strobe) begin
         unique case (regsel)
            REG_ENABLE_MASK: enable_in    = pwdata[MASK_W-1:0];
            REG_PERIOD_0:    period_in[0] = pwdata[PERIOD_W-1:0];
            REG_PERIOD_1:    period_in[1] = pwdata[PERIOD_W-1:0];
            REG_PERIOD_2:    period_in[2] = pwdata[PERIOD_W-1:0];
            REG_PERIOD_3:    period_in[3] = pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (regsel)
         REG_ENABLE_MASK: prdata = PDATA_W'(enable_ff);
         REG_PERIOD_0:    prdata = PDATA_W'(period_ff[0]);
         REG_PERIOD_1:    prdata = PDATA_W'(period_ff[1]);
         REG_PERIOD_2:    prdata = PDATA_W'(period_ff[2]);
         REG_PERIOD_3:    prdata = PDATA_W'(period_ff[3]);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            period_ff[i] <= PERIOD_W'(1);
         end
      end else begin
         enable_ff <= enable_in;
         period_ff <= period_in;
      end
   end

   assign enable_mask = enable_ff;
   assign periods     = period_ff;

endmodule

// ===== rtl/era_dpath.sv =====
`timescale 1ns / 1ps
// datapath: counters, snapshots, averages, fold stage and result register
module era_dpath import era_pkg::*; #(
   parameter int NUM_COUNTERS = NUM_COUNTERS_DEF,
   parameter int PERIOD_SLOTS = PERIOD_SLOTS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  logic [IDX_W-1:0]  req_counter_index,
   input  logic [TOCK_W-1:0] req_tock_number,
   input  period_bank_type   periods,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_which_counter,
   output logic [IDX_W-1:0]  rsp_which_period,
   output logic [AVG_W-1:0]  rsp_average_value,
   output logic [EVT_W-1:0]  rsp_events_since_tock,
   output logic              rsp_was_updated,
   output logic              rsp_last_result
);

   localparam int CIDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
   localparam int PIDX_W = (PERIOD_SLOTS > 1) ? $clog2(PERIOD_SLOTS) : 1;
   localparam int SUM_W  = ((COUNT_BITS > AVG_W) ? COUNT_BITS : AVG_W) + 1;
   localparam int WIDE_W = (COUNT_BITS > EVT_W) ? COUNT_BITS : EVT_W;
   localparam logic [AVG_W-1:0] AVG_MAX = '1;

   // architectural state
   logic [COUNT_BITS-1:0] event_count_ff [NUM_COUNTERS];
   logic [COUNT_BITS-1:0] last_count_ff  [NUM_COUNTERS];
   logic [COUNT_BITS-1:0] last_diff_ff   [NUM_COUNTERS];
   logic [COUNT_BITS-1:0] snapshot_ff    [NUM_COUNTERS][PERIOD_SLOTS];
   logic [AVG_W-1:0]      average_ff     [NUM_COUNTERS][PERIOD_SLOTS];

   // fold stage, loaded in ST_LOAD ahead of the commit in ST_COMMIT
   logic [COUNT_BITS-1:0] st_cnt_ff, st_diff_ff, st_delta_ff;
   logic [AVG_W-1:0]      st_kept_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_counter_ff, rsp_period_ff;
   logic [AVG_W-1:0]      rsp_avg_ff;
   logic [EVT_W-1:0]      rsp_events_ff;
   logic                  rsp_updated_ff, rsp_last_ff;

   logic [CIDX_W-1:0]       c_idx, inc_idx;
   logic [PIDX_W-1:0]       p_idx;
   logic                    inc_ok;
   logic [PERIOD_SLOTS-1:0] hit_vec;
   logic                    phase_done;
   logic                    hit;
   logic [AVG_W+2:0]        times7;
   logic [COUNT_BITS-1:0]   load_cnt;
   logic [SUM_W-1:0]        fold_sum;
   logic [AVG_W-1:0]        avg_new;
   logic [COUNT_BITS-1:0]   events_sel;
   logic [WIDE_W-1:0]       events_wide;

   era_phase #(
      .PERIOD_SLOTS (PERIOD_SLOTS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.phase_start),
      .tock_number (req_tock_number),
      .periods     (periods),
      .done        (phase_done),
      .hit         (hit_vec)
   );

   assign c_idx   = cmd.cur_c[CIDX_W-1:0];
   assign p_idx   = cmd.cur_p[PIDX_W-1:0];
   assign inc_idx = req_counter_index[CIDX_W-1:0];
   assign inc_ok  = ({1'b0, req_counter_index} < (IDX_W + 1)'(NUM_COUNTERS));
   assign hit     = hit_vec[p_idx];

   // load side: avg*7/8 and the two counter differences
   assign load_cnt = event_count_ff[c_idx];
   assign times7   = {average_ff[c_idx][p_idx], 3'b000}
                   - (AVG_W + 3)'(average_ff[c_idx][p_idx]);

   // commit side: add and saturate
   assign fold_sum = SUM_W'(st_kept_ff) + SUM_W'(st_delta_ff);
   assign avg_new  = (fold_sum > SUM_W'(AVG_MAX)) ? AVG_MAX : fold_sum[AVG_W-1:0];

   assign events_sel  = cmd.first_pair ? st_diff_ff : last_diff_ff[c_idx];
   assign events_wide = WIDE_W'(events_sel);

   always_ff @(posedge clock) begin
      if (cmd.pair_load) begin
         st_cnt_ff   <= load_cnt;
         st_diff_ff  <= load_cnt - last_count_ff[c_idx];
         st_delta_ff <= load_cnt - snapshot_ff[c_idx][p_idx];
         st_kept_ff  <= times7[AVG_W+2:3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_COUNTERS; c++) begin
            event_count_ff[c] <= '0;
            last_count_ff[c]  <= '0;
            last_diff_ff[c]   <= '0;
            for (int p = 0; p < PERIOD_SLOTS; p++) begin
               snapshot_ff[c][p] <= '0;
               average_ff[c][p]  <= '0;
            end
         end
      end else begin
         if (cmd.count_inc && inc_ok) begin
            event_count_ff[inc_idx] <= event_count_ff[inc_idx] + COUNT_BITS'(1);
         end
         if (cmd.pair_commit) begin
            if (cmd.first_pair) begin
               last_diff_ff[c_idx]  <= st_diff_ff;
               last_count_ff[c_idx] <= st_cnt_ff;
            end
            if (hit) begin
               average_ff[c_idx][p_idx]  <= avg_new;
               snapshot_ff[c_idx][p_idx] <= st_cnt_ff;
            end
         end
      end
   end

   // result register: a new transaction loads while the old one drains
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.pair_commit && cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pair_commit && cmd.emit) begin
         rsp_counter_ff <= cmd.cur_c;
         rsp_period_ff  <= cmd.cur_p;
         rsp_avg_ff     <= hit ? avg_new : average_ff[c_idx][p_idx];
         rsp_events_ff  <= events_wide[EVT_W-1:0];
         rsp_updated_ff <= hit;
         rsp_last_ff    <= cmd.last;
      end
   end

   assign status.phase_done = phase_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_which_counter     = rsp_counter_ff;
   assign rsp_which_period      = rsp_period_ff;
   assign rsp_average_value     = rsp_avg_ff;
   assign rsp_events_since_tock = rsp_events_ff;
   assign rsp_was_updated       = rsp_updated_ff;
   assign rsp_last_result       = rsp_last_ff;

endmodule

// ===== rtl/era_ctrl.sv =====
`timescale 1ns / 1ps
// controller: accepts items and walks counters and period slots on a tock
module era_ctrl import era_pkg::*; #(
   parameter int NUM_COUNTERS = NUM_COUNTERS_DEF,
   parameter int PERIOD_SLOTS = PERIOD_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [CMD_W-1:0]  req_cmd,
   output logic              req_ready,
   input  logic [MASK_W-1:0] enable_mask,
   input  dp_status_type     status,
   output ctrl_cmd_type      cmd
);

   localparam int CIDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
   localparam int PIDX_W = (PERIOD_SLOTS > 1) ? $clog2(PERIOD_SLOTS) : 1;
   localparam logic [CIDX_W-1:0] C_LAST = CIDX_W'(NUM_COUNTERS - 1);
   localparam logic [PIDX_W-1:0] P_LAST = PIDX_W'(PERIOD_SLOTS - 1);
   localparam logic [MASK_W-1:0] MASK_LIMIT = MASK_W'((1 << NUM_COUNTERS) - 1);

   state_type         state_ff, state_in;
   logic [CIDX_W-1:0] c_ff, c_in;
   logic [PIDX_W-1:0] p_ff, p_in;
   logic [NRES_W-1:0] n_ff, n_in;

   logic [MASK_W-1:0] en_eff;
   logic              cnt_on, higher_on, last_c, last_p, emit_ok, commit_go;
   logic              tock_accept, count_accept;

   always_comb begin
      en_eff       = enable_mask & MASK_LIMIT;
      cnt_on       = en_eff[c_ff];
      higher_on    = |((en_eff >> c_ff) >> 1);
      last_c       = (c_ff == C_LAST);
      last_p       = (p_ff == P_LAST);
      emit_ok      = (n_ff < NRES_W'(MAX_RESULTS));
      commit_go    = !emit_ok || status.out_free;
      tock_accept  = (state_ff == ST_IDLE) && req_valid && (req_cmd == CMD_TOCK);
      count_accept = (state_ff == ST_IDLE) && req_valid && (req_cmd == CMD_COUNT);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (tock_accept) state_in = ST_PHASE;
         end
         ST_PHASE: begin
            if (status.phase_done) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (cnt_on) state_in = ST_COMMIT;
            else if (last_c) state_in = ST_IDLE;
         end
         ST_COMMIT: begin
            if (commit_go) state_in = (last_c && last_p) ? ST_IDLE : ST_LOAD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // walk position and result count
   always_comb begin
      c_in = c_ff;
      p_in = p_ff;
      n_in = n_ff;
      priority if (tock_accept) begin
         c_in = '0;
         p_in = '0;
         n_in = '0;
      end else if ((state_ff == ST_LOAD) && !cnt_on) begin
         c_in = c_ff + CIDX_W'(1);
         p_in = '0;
      end else if ((state_ff == ST_COMMIT) && commit_go) begin
         n_in = n_ff + NRES_W'(emit_ok);
         if (last_p) begin
            p_in = '0;
            c_in = c_ff + CIDX_W'(1);
         end else begin
            p_in = p_ff + PIDX_W'(1);
         end
      end else begin
      end
   end

   // outputs
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      cmd.count_inc   = count_accept;
      cmd.phase_start = tock_accept;
      cmd.pair_load   = (state_ff == ST_LOAD) && cnt_on;
      cmd.pair_commit = (state_ff == ST_COMMIT) && commit_go;
      cmd.first_pair  = (p_ff == '0);
      cmd.emit        = emit_ok;
      cmd.last        = (n_ff == NRES_W'(MAX_RESULTS - 1)) || (last_p && !higher_on);
      cmd.cur_c       = IDX_W'(c_ff);
      cmd.cur_p       = IDX_W'(p_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         c_ff     <= '0;
         p_ff     <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         c_ff     <= c_in;
         p_ff     <= p_in;
         n_ff     <= n_in;
      end
   end

endmodule

// ===== rtl/event_rate_averager_unit.sv =====
`timescale 1ns / 1ps
// top level of the event rate averager
//
// Keeps NUM_COUNTERS wrapping event counters of COUNT_BITS bits and, for each
// counter and each of PERIOD_SLOTS shared period slots, an average that is
// folded as average*7/8 + delta (saturating at 2^36-1) whenever the tock
// number hits the slot's phase (tock mod period == period-1, a zero period
// acts as one). A count transaction adds one to the selected counter; an
// index beyond the built counters is ignored. A tock transaction is
// accepted, then runs the bit-serial remainder lanes (one tock bit per
// cycle, all period slots in parallel), starts the walk, then does a load
// and a commit per enabled counter and slot and skips each disabled
// counter; a commit waits while the result register is full and not taken.
// One result transaction is made per enabled counter and slot in ascending
// order, at most twelve, the final one flagged by last_result. A finished
// result waits in an output register while the next item is accepted.
// Registers (word at byte 4*i): 0 enable_mask, 1..4 period_0..period_3;
// writes are expected only while the block is idle, and no clearing pass
// runs after reset.
module event_rate_averager_unit import era_pkg::*; #(
   parameter int NUM_COUNTERS = NUM_COUNTERS_DEF,
   parameter int PERIOD_SLOTS = PERIOD_SLOTS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   era_req_if.sink            req_chan,
   era_rsp_if.source          rsp_chan,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   // configuration
   logic [MASK_W-1:0] enable_mask;
   period_bank_type   periods;

   // controller to datapath
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   era_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .enable_mask (enable_mask),
      .periods     (periods)
   );

   // state machine: idle, remainder wait, then load/commit per counter and slot
   era_ctrl #(
      .NUM_COUNTERS (NUM_COUNTERS),
      .PERIOD_SLOTS (PERIOD_SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_cmd     (req_chan.cmd),
      .req_ready   (req_ready),
      .enable_mask (enable_mask),
      .status      (status),
      .cmd         (cmd)
   );

   assign req_chan.ready = req_ready;

   // counters, averages, fold stage and the result register
   era_dpath #(
      .NUM_COUNTERS (NUM_COUNTERS),
      .PERIOD_SLOTS (PERIOD_SLOTS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_counter_index     (req_chan.counter_index),
      .req_tock_number       (req_chan.tock_number),
      .periods               (periods),
      .rsp_valid             (rsp_chan.valid),
      .rsp_ready             (rsp_chan.ready),
      .rsp_which_counter     (rsp_chan.which_counter),
      .rsp_which_period      (rsp_chan.which_period),
      .rsp_average_value     (rsp_chan.average_value),
      .rsp_events_since_tock (rsp_chan.events_since_tock),
      .rsp_was_updated       (rsp_chan.was_updated),
      .rsp_last_result       (rsp_chan.last_result)
   );

endmodule
